// ----- sv/swarq_pkg.sv -----
package swarq_pkg;

   localparam int MESSAGE_BYTES_DEF = 20;
   localparam int QUEUE_DEPTH_DEF   = 16;

   // Input item commands.
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_REPLY   = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // Result item kinds.
   localparam logic [2:0] KIND_STOP  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_HDR   = 3'd2;
   localparam logic [2:0] KIND_BYTE  = 3'd3;
   localparam logic [2:0] KIND_DROP  = 3'd4;

   typedef struct packed {
      logic       byte_op;
      logic       enqueue;
      logic       pop;
      logic       load;
      logic [2:0] load_kind;
      logic       load_last;
      logic       rd_clr;
      logic       rd_inc;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic count_gt1;
      logic msg_last;
      logic discarding;
      logic ack_match;
      logic out_free;
      logic rd_last;
   } stat_type;

endpackage

// ----- sv/swarq_if.sv -----
interface swarq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  msg_byte;
   logic [31:0] reply_seq;
   logic        reply_is_ack;

   modport source (output valid, cmd, msg_byte, reply_seq, reply_is_ack, input ready);
   modport sink   (input valid, cmd, msg_byte, reply_seq, reply_is_ack, output ready);
endinterface

interface swarq_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [31:0]        seq_out;
   logic signed [31:0] checksum_out;
   logic [7:0]         data_byte;
   logic               last;

   modport source (output valid, kind, seq_out, checksum_out, data_byte, last, input ready);
   modport sink   (input valid, kind, seq_out, checksum_out, data_byte, last, output ready);
endinterface

// ----- sv/swarq_ram.sv -----
module swarq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/swarq_ctrl.sv -----
module swarq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_cmd,
   output logic               req_ready,
   input  swarq_pkg::stat_type stat,
   output swarq_pkg::ctrl_type ctrl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DROP  = 3'd1;
   localparam logic [2:0] ST_STOP  = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_HDR   = 3'd4;
   localparam logic [2:0] ST_BYTE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       awaiting_ff, awaiting_in;
   logic       plan_start_ff, plan_start_in;
   logic       plan_pkt_ff, plan_pkt_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      awaiting_in   = awaiting_ff;
      plan_start_in = plan_start_ff;
      plan_pkt_in   = plan_pkt_ff;
      ctrl          = '0;
      ctrl.load_kind = swarq_pkg::KIND_STOP;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  swarq_pkg::CMD_BYTE: begin
                     ctrl.byte_op = 1'b1;
                     if (stat.msg_last) begin
                        if (stat.discarding || stat.full) begin
                           state_in = ST_DROP;
                        end else begin
                           ctrl.enqueue = 1'b1;
                           if (!awaiting_ff) begin
                              awaiting_in = 1'b1;
                              plan_pkt_in = 1'b1;
                              state_in    = ST_START;
                           end
                        end
                     end
                  end
                  swarq_pkg::CMD_REPLY: begin
                     state_in = ST_STOP;
                     if (stat.ack_match) begin
                        ctrl.pop = !stat.empty;
                        // The next packet goes out only if one stays queued after the pop.
                        plan_start_in = stat.count_gt1;
                        plan_pkt_in   = stat.count_gt1;
                        if (!stat.count_gt1) begin
                           awaiting_in = 1'b0;
                        end
                     end else begin
                        plan_start_in = 1'b1;
                        plan_pkt_in   = !stat.empty;
                     end
                  end
                  swarq_pkg::CMD_TIMEOUT: begin
                     state_in    = ST_START;
                     plan_pkt_in = !stat.empty;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DROP: begin
            if (stat.out_free) begin
               ctrl.load      = 1'b1;
               ctrl.load_kind = swarq_pkg::KIND_DROP;
               ctrl.load_last = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_STOP: begin
            if (stat.out_free) begin
               ctrl.load      = 1'b1;
               ctrl.load_kind = swarq_pkg::KIND_STOP;
               ctrl.load_last = !plan_start_ff;
               state_in       = plan_start_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            // Point the payload read at the first byte so it is ready for ST_HDR.
            ctrl.rd_clr = 1'b1;
            if (stat.out_free) begin
               ctrl.load      = 1'b1;
               ctrl.load_kind = swarq_pkg::KIND_START;
               ctrl.load_last = !plan_pkt_ff;
               state_in       = plan_pkt_ff ? ST_HDR : ST_IDLE;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               ctrl.load      = 1'b1;
               ctrl.load_kind = swarq_pkg::KIND_HDR;
               state_in       = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (stat.out_free) begin
               ctrl.load      = 1'b1;
               ctrl.load_kind = swarq_pkg::KIND_BYTE;
               ctrl.load_last = stat.rd_last;
               ctrl.rd_inc    = !stat.rd_last;
               state_in       = stat.rd_last ? ST_IDLE : ST_BYTE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         awaiting_ff   <= 1'b0;
         plan_start_ff <= 1'b0;
         plan_pkt_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         awaiting_ff   <= awaiting_in;
         plan_start_ff <= plan_start_in;
         plan_pkt_ff   <= plan_pkt_in;
      end
   end

endmodule

// ----- sv/swarq_dp.sv -----
module swarq_dp #(
   parameter int MESSAGE_BYTES = swarq_pkg::MESSAGE_BYTES_DEF,
   parameter int QUEUE_DEPTH   = swarq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  swarq_pkg::ctrl_type ctrl,
   output swarq_pkg::stat_type stat,
   input  logic [7:0]          req_msg_byte,
   input  logic [31:0]         req_reply_seq,
   input  logic                req_reply_is_ack,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [31:0]         rsp_seq_out,
   output logic signed [31:0]  rsp_checksum_out,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last
);

   localparam int IDX_W   = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int PAY_D   = QUEUE_DEPTH * MESSAGE_BYTES;
   localparam int PAY_AW  = (PAY_D > 1) ? $clog2(PAY_D) : 1;
   localparam int PROD_W  = IDX_W + 10;

   logic [31:0]      exp_seq_ff, exp_seq_in;
   logic [31:0]      nas_ff, nas_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [31:0]      sum_ff, sum_in;
   logic             discard_ff, discard_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff;
   logic [31:0]        rsp_seq_ff;
   logic signed [31:0] rsp_chk_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_last_ff;

   logic [IDX_W:0]          weight;
   logic signed [PROD_W-1:0] prod;
   logic [31:0]             term;
   logic [31:0]             chk_wdata;
   logic [31:0]             chk_q;
   logic [7:0]              pay_q;
   logic                    pay_we;
   logic [PAY_AW-1:0]       pay_waddr;
   logic [PAY_AW-1:0]       pay_raddr;
   logic                    full;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));

   // Weighted checksum term: signed byte times its one-based position.
   assign weight    = {1'b0, byte_idx_ff} + (IDX_W + 1)'(1);
   assign prod      = $signed(req_msg_byte) * $signed({1'b0, weight});
   assign term      = 32'(prod);
   assign chk_wdata = nas_ff + sum_ff + term;

   assign pay_we    = ctrl.byte_op && !full;
   assign pay_waddr = PAY_AW'(tail_ff) * PAY_AW'(MESSAGE_BYTES) + PAY_AW'(byte_idx_ff);
   assign pay_raddr = PAY_AW'(head_ff) * PAY_AW'(MESSAGE_BYTES) + PAY_AW'(rd_idx_in);

   assign stat.full       = full;
   assign stat.empty      = (count_ff == '0);
   assign stat.count_gt1  = (count_ff > CNT_W'(1));
   assign stat.msg_last   = (byte_idx_ff == IDX_W'(MESSAGE_BYTES - 1));
   assign stat.discarding = discard_ff;
   assign stat.ack_match  = req_reply_is_ack && (req_reply_seq == exp_seq_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.rd_last    = (rd_idx_ff == IDX_W'(MESSAGE_BYTES - 1));

   always_comb begin
      exp_seq_in  = exp_seq_ff;
      nas_in      = nas_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      byte_idx_in = byte_idx_ff;
      sum_in      = sum_ff;
      discard_in  = discard_ff;
      rd_idx_in   = rd_idx_ff;

      if (ctrl.byte_op) begin
         if (stat.msg_last) begin
            byte_idx_in = '0;
            sum_in      = '0;
            discard_in  = 1'b0;
         end else begin
            byte_idx_in = byte_idx_ff + IDX_W'(1);
            sum_in      = sum_ff + term;
            discard_in  = discard_ff || full;
         end
      end
      if (ctrl.enqueue) begin
         tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
         nas_in   = nas_ff + 32'd1;
      end
      if (ctrl.pop) begin
         head_in    = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in   = count_ff - CNT_W'(1);
         exp_seq_in = exp_seq_ff + 32'd1;
      end
      if (ctrl.rd_clr) begin
         rd_idx_in = '0;
      end else if (ctrl.rd_inc) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end

      if (ctrl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_seq_ff   <= 32'd1;
         nas_ff       <= 32'd1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         byte_idx_ff  <= '0;
         sum_ff       <= '0;
         discard_ff   <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exp_seq_ff   <= exp_seq_in;
         nas_ff       <= nas_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         byte_idx_ff  <= byte_idx_in;
         sum_ff       <= sum_in;
         discard_ff   <= discard_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rsp_kind_ff <= ctrl.load_kind;
         rsp_last_ff <= ctrl.load_last;
         rsp_seq_ff  <= (ctrl.load_kind == swarq_pkg::KIND_HDR) ? exp_seq_ff : '0;
         rsp_chk_ff  <= (ctrl.load_kind == swarq_pkg::KIND_HDR) ? $signed(chk_q) : '0;
         rsp_data_ff <= (ctrl.load_kind == swarq_pkg::KIND_BYTE) ? pay_q : '0;
      end
   end

   swarq_ram #(
      .WIDTH(32),
      .DEPTH(QUEUE_DEPTH)
   ) u_chk_ram (
      .clock   (clock),
      .wr_en   (ctrl.enqueue),
      .wr_addr (tail_ff),
      .wr_data (chk_wdata),
      .rd_addr (head_ff),
      .rd_data (chk_q)
   );

   swarq_ram #(
      .WIDTH(8),
      .DEPTH(PAY_D)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (req_msg_byte),
      .rd_addr (pay_raddr),
      .rd_data (pay_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_seq_out      = rsp_seq_ff;
   assign rsp_checksum_out = rsp_chk_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- sv/stop_and_wait_arq_sender.sv -----
// Message bytes are taken one per cycle while no results are being produced.
// An item with results holds req ready low while they are loaded into the output
// register, one per cycle when rsp ready stays high. A full transmission is the start,
// the header and MESSAGE_BYTES payload bytes read from the registered payload memory.
// Synchronous reset clears the controller and queue state at once; the payload and
// checksum memories are not cleared.
module stop_and_wait_arq_sender #(
   parameter int MESSAGE_BYTES = swarq_pkg::MESSAGE_BYTES_DEF,
   parameter int QUEUE_DEPTH   = swarq_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   swarq_req_if.sink   req_ch,
   swarq_rsp_if.source rsp_ch
);

   swarq_pkg::ctrl_type ctrl;
   swarq_pkg::stat_type stat;

   swarq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   swarq_dp #(
      .MESSAGE_BYTES (MESSAGE_BYTES),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_msg_byte     (req_ch.msg_byte),
      .req_reply_seq    (req_ch.reply_seq),
      .req_reply_is_ack (req_ch.reply_is_ack),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_kind         (rsp_ch.kind),
      .rsp_seq_out      (rsp_ch.seq_out),
      .rsp_checksum_out (rsp_ch.checksum_out),
      .rsp_data_byte    (rsp_ch.data_byte),
      .rsp_last         (rsp_ch.last)
   );

endmodule

// ----- sv/swarq_checker.sv -----
module swarq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_seq_out,
   input logic [31:0] rsp_checksum_out,
   input logic        rsp_last
);

   // A stalled result item keeps its valid and its kind.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_kind_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind))
      else $error("result kind changed while stalled");

   // A header is always followed by its payload bytes.
   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == swarq_pkg::KIND_HDR |-> !rsp_last)
      else $error("header marked as last item");

   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == swarq_pkg::KIND_DROP |-> rsp_last)
      else $error("drop report not marked as last item");

   a_hdr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != swarq_pkg::KIND_HDR |-> rsp_seq_out == '0 && rsp_checksum_out == '0)
      else $error("header fields nonzero outside a header");

endmodule

bind stop_and_wait_arq_sender swarq_checker u_swarq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_seq_out      (rsp_ch.seq_out),
   .rsp_checksum_out (rsp_ch.checksum_out),
   .rsp_last         (rsp_ch.last)
);

// ----- verif/swarq_tb_pkg.sv -----
package swarq_tb_pkg;
   import swarq_pkg::*;

   // Command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  msg_byte;
      logic [31:0] reply_seq;
      logic        reply_is_ack;
   } arq_req_type;

   typedef struct {
      logic [2:0]         kind;
      logic [31:0]        seq_out;
      logic signed [31:0] checksum_out;
      logic [7:0]         data_byte;
      logic               last;
   } arq_rsp_type;

   class arq_scoreboard;
      bit          awaiting;
      bit [31:0]   ack_seq;
      bit [31:0]   assign_seq;
      bit [7:0]    payload_mem [QUEUE_DEPTH_DEF][MESSAGE_BYTES_DEF];
      bit [31:0]   chk_mem [QUEUE_DEPTH_DEF];
      int unsigned head;
      int unsigned tail;
      int unsigned queued;
      int unsigned byte_idx;
      bit [31:0]   msg_sum;
      bit          dropping;
      arq_rsp_type tx_expected[$];
      arq_rsp_type burst[$];
      int          errors;

      function new();
         awaiting   = 1'b0;
         ack_seq    = 32'd1;
         assign_seq = 32'd1;
         head       = 0;
         tail       = 0;
         queued     = 0;
         byte_idx   = 0;
         msg_sum    = '0;
         dropping   = 1'b0;
         errors     = 0;
      endfunction

      function void push_tx(logic [2:0] kind, logic [31:0] seq = '0, logic [31:0] chk = '0,
                            logic [7:0] data = '0);
         arq_rsp_type r;
         r.kind         = kind;
         r.seq_out      = seq;
         r.checksum_out = chk;
         r.data_byte    = data;
         r.last         = 1'b0;
         burst.push_back(r);
      endfunction

      // A transmission is the header of the head packet and its payload bytes.
      function void push_head_packet();
         push_tx(KIND_HDR, ack_seq, chk_mem[head]);
         for (int i = 0; i < MESSAGE_BYTES_DEF; i++)
            push_tx(KIND_BYTE, '0, '0, payload_mem[head][i]);
      endfunction

      function void note_request(arq_req_type it);
         bit [31:0]   term;
         bit          matched;
         arq_rsp_type r;
         burst.delete();
         case (it.cmd)
            CMD_BYTE: begin
               if (byte_idx >= MESSAGE_BYTES_DEF)
                  byte_idx = 0;
               if (queued >= QUEUE_DEPTH_DEF)
                  dropping = 1'b1;
               else
                  payload_mem[tail][byte_idx] = it.msg_byte;
               term    = {{24{it.msg_byte[7]}}, it.msg_byte};
               msg_sum = msg_sum + term * (byte_idx + 1);
               byte_idx++;
               if (byte_idx >= MESSAGE_BYTES_DEF) begin
                  if (dropping) begin
                     push_tx(KIND_DROP);
                  end else begin
                     chk_mem[tail] = assign_seq + msg_sum;
                     tail          = (tail + 1) % QUEUE_DEPTH_DEF;
                     queued++;
                     assign_seq++;
                     if (!awaiting) begin
                        push_tx(KIND_START);
                        push_head_packet();
                        awaiting = 1'b1;
                     end
                  end
                  byte_idx = 0;
                  msg_sum  = '0;
                  dropping = 1'b0;
               end
            end
            CMD_REPLY: begin
               matched = it.reply_is_ack && (it.reply_seq == ack_seq);
               push_tx(KIND_STOP);
               if (matched) begin
                  if (queued > 0) begin
                     head = (head + 1) % QUEUE_DEPTH_DEF;
                     queued--;
                     ack_seq++;
                  end
                  if (queued > 0) begin
                     push_tx(KIND_START);
                     push_head_packet();
                  end else begin
                     awaiting = 1'b0;
                  end
               end else begin
                  push_tx(KIND_START);
                  if (queued > 0)
                     push_head_packet();
               end
            end
            CMD_TIMEOUT: begin
               push_tx(KIND_START);
               if (queued > 0)
                  push_head_packet();
            end
            default: ;
         endcase
         foreach (burst[i]) begin
            r      = burst[i];
            r.last = (i == burst.size() - 1);
            tx_expected.push_back(r);
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("MISMATCH %s: got %h, expected %h", what, got, want);
      endtask

      task check_response(arq_rsp_type got);
         arq_rsp_type want;
         if (tx_expected.size() == 0) begin
            report_mismatch("result item with nothing expected, kind", 32'(got.kind), '0);
            return;
         end
         want = tx_expected.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.seq_out !== want.seq_out)
            report_mismatch("seq_out", got.seq_out, want.seq_out);
         if (got.checksum_out !== want.checksum_out)
            report_mismatch("checksum_out", got.checksum_out, want.checksum_out);
         if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
         if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

endpackage

// ----- verif/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swarq_pkg::*;
   import swarq_tb_pkg::*;

   typedef enum {PACE_SRC_LIGHT, PACE_SRC_HEAVY, PACE_NONE} pace_type;

   logic          clock;
   logic          reset;
   logic          hold_go;
   bit            hold_done;
   int            hold_left;
   pace_type      pace;
   arq_scoreboard sb;

   swarq_req_if req_bus ();
   swarq_rsp_if rsp_bus ();

   stop_and_wait_arq_sender dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_top failed");
      $finish;
   end

   function automatic int src_gap_pct();
      case (pace)
         PACE_SRC_LIGHT: return 16;
         PACE_SRC_HEAVY: return 73;
         default:        return 0;
      endcase
   endfunction

   function automatic int sink_stall_pct();
      case (pace)
         PACE_SRC_LIGHT: return 73;
         PACE_SRC_HEAVY: return 16;
         default:        return 0;
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                            input logic [31:0] rseq, input logic ack);
      arq_req_type it;
      it.cmd          = cmd;
      it.msg_byte     = b;
      it.reply_seq    = rseq;
      it.reply_is_ack = ack;
      while ($urandom_range(99) < src_gap_pct()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= cmd;
      req_bus.msg_byte     <= b;
      req_bus.reply_seq    <= rseq;
      req_bus.reply_is_ack <= ack;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_request(it);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(CMD_BYTE, b, $urandom, 1'($urandom_range(1)));
   endtask

   task automatic send_ack();
      send_item(CMD_REPLY, 8'($urandom), sb.ack_seq, 1'b1);
   endtask

   task automatic send_timeout();
      send_item(CMD_TIMEOUT, 8'($urandom), $urandom, 1'($urandom_range(1)));
   endtask

   // Mostly matching ACKs, so that the queue drains; the rest are NAKs, ACKs of
   // the next (future) number, and random replies.
   task automatic send_random_reply();
      int r;
      r = $urandom_range(9);
      if (r < 6)
         send_ack();
      else if (r == 6)
         send_item(CMD_REPLY, 8'($urandom), sb.ack_seq, 1'b0);
      else if (r == 7)
         send_item(CMD_REPLY, 8'($urandom), sb.ack_seq + 32'd1, 1'b1);
      else
         send_item(CMD_REPLY, 8'($urandom), $urandom, 1'($urandom_range(1)));
   endtask

   task automatic send_message(input bit broken);
      for (int i = 0; i < MESSAGE_BYTES_DEF; i++) begin
         if (broken && $urandom_range(29) == 0) begin
            if ($urandom_range(1))
               send_random_reply();
            else
               send_timeout();
         end
         send_byte(pick_byte());
      end
   endtask

   task automatic random_traffic(input int target);
      int n;
      int r;
      n = 0;
      while (n < target) begin
         r = $urandom_range(99);
         if (r < 55) begin
            send_message(1'b1);
            n += MESSAGE_BYTES_DEF;
         end else if (r < 80) begin
            send_random_reply();
            n++;
         end else if (r < 90) begin
            send_timeout();
            n++;
         end else begin
            send_item(CMD_UNUSED, 8'($urandom), $urandom, 1'($urandom_range(1)));
         end
      end
   endtask

   // Result side: checks every accepted item, then chooses ready for the next cycle.
   initial begin
      arq_rsp_type got;
      rsp_bus.ready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.kind         = rsp_bus.kind;
            got.seq_out      = rsp_bus.seq_out;
            got.checksum_out = rsp_bus.checksum_out;
            got.data_byte    = rsp_bus.data_byte;
            got.last         = rsp_bus.last;
            sb.check_response(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct());
         end
      end
   end

   initial begin
      sb = new();
      pace = PACE_SRC_LIGHT;
      reset                <= 1'b1;
      hold_go              <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= CMD_BYTE;
      req_bus.msg_byte     <= '0;
      req_bus.reply_seq    <= '0;
      req_bus.reply_is_ack <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // While idle: a timer expiry, a matching ACK, a NAK, an ACK of the
      // all-ones number, and the unused command.
      send_timeout();
      send_item(CMD_REPLY, 8'h00, sb.ack_seq, 1'b1);
      send_item(CMD_REPLY, 8'hFF, sb.ack_seq, 1'b0);
      send_item(CMD_REPLY, 8'h5A, 32'hFFFF_FFFF, 1'b1);
      send_item(CMD_UNUSED, 8'hA5, 32'h0000_0000, 1'b0);
      // One message with the extreme byte values at the weighted positions.
      for (int i = 0; i < MESSAGE_BYTES_DEF; i++) begin
         case (i % 4)
            0: send_byte(8'h80);
            1: send_byte(8'h7F);
            2: send_byte(8'hFF);
            default: send_byte(8'h00);
         endcase
      end

      random_traffic(20);
      pace = PACE_SRC_HEAVY;
      random_traffic(20);

      // Hold off the result side while a message goes in, so that the output
      // register fills and the block stalls its input; the ACKs keep coming.
      pace = PACE_NONE;
      hold_go <= 1'b1;
      send_message(1'b0);
      while (sb.queued > 0)
         send_ack();
      send_ack();

      random_traffic(10);
      req_bus.valid <= 1'b0;

      while (sb.tx_expected.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.tx_expected.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
